// ----- rtl/sidlt_pkg.sv -----
// ----------------------------------------------------------------------------
// sidlt_pkg
// Shared types and codes for the sorted id/offset lookup table.
// ----------------------------------------------------------------------------
package sidlt_pkg;

  localparam int unsigned TableDepthDefault = 4096;
  localparam int unsigned HeldW             = 13;

  // command codes
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] key_id;
    logic [31:0] entry_offset;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [31:0]      found_offset;
    logic [HeldW-1:0] entries_held;
  } out_beat_t;

  // one table row
  typedef struct packed {
    logic [31:0] id;
    logic [31:0] offset;
  } entry_t;

endpackage

// ----- rtl/sidlt_mem.sv -----
// ----------------------------------------------------------------------------
// sidlt_mem
// Table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sidlt_mem #(
  parameter int unsigned TABLE_DEPTH = sidlt_pkg::TableDepthDefault,
  localparam int unsigned AW = $clog2(TABLE_DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  sidlt_pkg::entry_t wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output sidlt_pkg::entry_t rdata_o
);
  import sidlt_pkg::*;

  entry_t mem [TABLE_DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/sidlt_ctrl.sv -----
// ----------------------------------------------------------------------------
// sidlt_ctrl
// Sequencer: binary search with a shared compare unit, shift-up for insert.
// ----------------------------------------------------------------------------
module sidlt_ctrl #(
  parameter int unsigned TABLE_DEPTH = sidlt_pkg::TableDepthDefault,
  localparam int unsigned AW = $clog2(TABLE_DEPTH),
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  sidlt_pkg::in_beat_t  in_data_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output sidlt_pkg::out_beat_t res_data_o,
  output logic                 mem_we_o,
  output logic [AW-1:0]        mem_waddr_o,
  output sidlt_pkg::entry_t    mem_wdata_o,
  output logic                 mem_re_o,
  output logic [AW-1:0]        mem_raddr_o,
  input  sidlt_pkg::entry_t    mem_rdata_i
);
  import sidlt_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SRCH  = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_SHRD  = 3'd4;
  localparam logic [2:0] S_SHWR  = 3'd5;
  localparam logic [2:0] S_PUT   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  localparam logic [CW-1:0] Full = CW'(TABLE_DEPTH);

  logic [2:0]    state_q, state_d;
  logic [1:0]    cmd_q, cmd_d;
  logic [31:0]   key_q, key_d;
  logic [31:0]   off_q, off_d;
  logic [CW-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [CW-1:0] idx_q, idx_d, count_q, count_d;
  logic [1:0]    status_q, status_d;
  logic [31:0]   found_q, found_d;

  logic [CW-1:0] lo_n, hi_n, mid_n, idx_m1;
  logic          go_right;

  // shared compare unit
  assign go_right = (cmd_q == CMD_INSERT) ? (mem_rdata_i.id <= key_q)
                                          : (mem_rdata_i.id <  key_q);
  assign idx_m1   = idx_q - CW'(1);

  always_comb begin
    lo_n = lo_q;
    hi_n = hi_q;
    if (state_q == S_CMP) begin
      if (go_right) begin
        lo_n = mid_q + CW'(1);
      end else begin
        hi_n = mid_q;
      end
    end
    mid_n = lo_n + ((hi_n - lo_n) >> 1);
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    off_d       = off_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    idx_d       = idx_q;
    count_d     = count_q;
    status_d    = status_q;
    found_d     = found_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = lo_q[AW-1:0];
    mem_wdata_o = mem_rdata_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = mid_n[AW-1:0];
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_d    = in_data_i.command;
          key_d    = in_data_i.key_id;
          off_d    = in_data_i.entry_offset;
          lo_d     = '0;
          hi_d     = count_q;
          status_d = ST_OK;
          found_d  = '0;
          case (in_data_i.command)
            CMD_CLEAR: begin
              count_d = '0;
              state_d = S_DONE;
            end
            CMD_INSERT: begin
              if (count_q == Full) begin
                status_d = ST_FULL;
                state_d  = S_DONE;
              end else begin
                state_d = S_SRCH;
              end
            end
            CMD_LOOKUP: state_d = S_SRCH;
            default:    state_d = S_DONE;
          endcase
        end
      end

      S_SRCH, S_CMP: begin
        lo_d = lo_n;
        hi_d = hi_n;
        if (lo_n < hi_n) begin
          // next probe
          mem_re_o    = 1'b1;
          mem_raddr_o = mid_n[AW-1:0];
          mid_d       = mid_n;
          state_d     = S_CMP;
        end else if (cmd_q == CMD_LOOKUP) begin
          if (lo_n < count_q) begin
            mem_re_o    = 1'b1;
            mem_raddr_o = lo_n[AW-1:0];
            state_d     = S_CHECK;
          end else begin
            status_d = ST_NOT_FOUND;
            state_d  = S_DONE;
          end
        end else if (lo_n == count_q) begin
          state_d = S_PUT;
        end else begin
          idx_d   = count_q;
          state_d = S_SHRD;
        end
      end

      S_CHECK: begin
        if (mem_rdata_i.id == key_q) begin
          found_d = mem_rdata_i.offset;
        end else begin
          status_d = ST_NOT_FOUND;
        end
        state_d = S_DONE;
      end

      S_SHRD: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = idx_m1[AW-1:0];
        state_d     = S_SHWR;
      end

      S_SHWR: begin
        // move row idx-1 up to idx
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q[AW-1:0];
        mem_wdata_o = mem_rdata_i;
        idx_d       = idx_m1;
        state_d     = (idx_m1 == lo_q) ? S_PUT : S_SHRD;
      end

      S_PUT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = lo_q[AW-1:0];
        mem_wdata_o = '{id: key_q, offset: off_q};
        count_d     = count_q + CW'(1);
        state_d     = S_DONE;
      end

      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign res_data_o = '{status:       status_q,
                        found_offset: found_q,
                        entries_held: HeldW'(count_q)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    key_q    <= key_d;
    off_q    <= off_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    idx_q    <= idx_d;
    status_q <= status_d;
    found_q  <= found_d;
  end

endmodule

// ----- rtl/sorted_id_offset_lookup_table.sv -----
// ----------------------------------------------------------------------------
// Sorted id/offset lookup table: binary search of P <= log2(n)+1 probes. A lookup
// checks row pos unless past the end; insert shifts rows pos..n-1 up, then writes.
// Clear, full, unused code answer directly. One command in the sequencer; a done
// beat may wait in the output register. Reset clears the entry count, not the rows.
// ----------------------------------------------------------------------------
module sorted_id_offset_lookup_table #(
  parameter int unsigned TABLE_DEPTH = sidlt_pkg::TableDepthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  sidlt_pkg::in_beat_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output sidlt_pkg::out_beat_t out_data_o
);
  import sidlt_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  // Result handoff from the sequencer into the output register.
  logic      res_valid, res_ready;
  out_beat_t res_data;

  // Memory port signals.
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  entry_t        mem_wdata, mem_rdata;

  // Output register: a finished beat waits here so the sequencer can take
  // the next command while the consumer stalls.
  logic      out_valid_q;
  out_beat_t out_data_q;

  assign res_ready = !out_valid_q || out_ready_i;

  sidlt_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_data_o  (res_data),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // Rows hold {id, offset}; kept in ascending id order by the sequencer.
  sidlt_mem #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= res_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- rtl/sidlt_checker.sv -----
// ----------------------------------------------------------------------------
// sidlt_checker
// Port-level checks for the sorted id/offset lookup table.
// ----------------------------------------------------------------------------
module sidlt_checker #(
  parameter int unsigned TABLE_DEPTH = sidlt_pkg::TableDepthDefault
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input sidlt_pkg::in_beat_t  in_data_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input sidlt_pkg::out_beat_t out_data_o
);
  import sidlt_pkg::*;

  // waiting input beat holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("input beat changed while waiting");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // one command at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_FULL |->
      out_data_o.found_offset == '0 &&
      out_data_o.entries_held == HeldW'(TABLE_DEPTH))
    else $error("table full answer inconsistent");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_NOT_FOUND |->
      out_data_o.found_offset == '0)
    else $error("miss with nonzero offset");

endmodule

bind sorted_id_offset_lookup_table sidlt_checker #(
  .TABLE_DEPTH(TABLE_DEPTH)
) u_sidlt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
